/* hw/rtl/mfqs_pkg.sv */
package mfqs_pkg;
  localparam int LEVELS_DEF  = 10;
  localparam int CLASSES_DEF = 4;
  localparam int THREADS_DEF = 64;

  localparam logic [1:0] ST_ENQ  = 2'd0;
  localparam logic [1:0] ST_DISP = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic CMD_ENQ  = 1'b0;
  localparam logic CMD_DISP = 1'b1;

  // Slice for a level: 2^level, kept to 10 bits.
  function automatic logic [9:0] slice_of(input logic [3:0] lv);
    logic [9:0] s;
    s = '0;
    if (lv < 4'd10) s = 10'(1) << lv;
    return s;
  endfunction
endpackage

/* hw/rtl/mfqs_slot_ram.sv */
// Slot store of all FIFOs; registered read.
module mfqs_slot_ram #(
  parameter int DEPTH = 2560,
  parameter int AW    = 12,
  parameter int DW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/multilevel_feedback_queue_scheduler.sv */
// Feedback-queue scheduler, one beat in, one beat out per command.
// Enqueue steps: table read, run add and level check, FIFO state read, commit;
// dispatch scans the FIFOs one per cycle, passing empty ones, then reads the slot and
// thread table; nothing ready ends after the scan of all FIFOs.
// One command at a time: the next beat is taken the cycle after a result is loaded;
// a waiting result holds only the next command, at its result stage.
// rst (sync, high) clears thread table valid bits, FIFO busy flags and the total.
module multilevel_feedback_queue_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [5:0]  thread_id,
  input  logic [1:0]  thread_class,
  input  logic [31:0] service_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  chosen_thread,
  output logic [3:0]  chosen_level,
  output logic [9:0]  slice_ticks,
  output logic [31:0] level_run,
  output logic [11:0] waiting_count
);
  // THREADS and CLASSES are powers of two matching the id and class ports,
  // so ids and classes index the tables directly.
  localparam int LEVELS  = mfqs_pkg::LEVELS_DEF;
  localparam int CLASSES = mfqs_pkg::CLASSES_DEF;
  localparam int THREADS = mfqs_pkg::THREADS_DEF;
  localparam int NQ  = LEVELS * CLASSES;
  localparam int QW  = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int TW  = $clog2(THREADS);
  localparam int FW  = $clog2(THREADS + 1);
  localparam int AW  = $clog2(NQ * THREADS);
  localparam int LW  = $clog2(LEVELS);
  localparam int QSW = TW + FW;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_LEVEL, S_QREAD, S_COMMIT, S_SCAN, S_READ, S_TREAD, S_DONE
  } state_t;
  state_t state;

  // thread table, cleared at reset via valid bits; registered reads
  logic [THREADS-1:0] tvalid;
  logic [LW-1:0]  t_level [THREADS];
  logic [31:0]    t_run   [THREADS];
  logic [31:0]    t_last  [THREADS];
  // per-FIFO {head, fill}; meaningful only while the FIFO's busy flag is set,
  // an idle FIFO reads as head 0, fill 0
  logic [QSW-1:0] q_state [NQ];
  logic [NQ-1:0]  q_busy;
  logic [QSW-1:0] qs;
  logic [11:0]    total;

  logic [TW-1:0]  tid;
  logic [QW-1:0]  cls;
  logic [31:0]    svc;
  logic [LW-1:0]  lvl;
  logic [31:0]    run;
  logic [31:0]    prev_svc;
  logic           rd_ok;
  logic [QW-1:0]  q;
  logic [LW-1:0]  scan_lv;
  logic [QW-1:0]  scan_cl;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [5:0]     ram_wdata, ram_rdata;

  mfqs_slot_ram #(.DEPTH(NQ * THREADS), .AW(AW), .DW(6)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [TW-1:0] q_hd;
  logic [FW-1:0] q_fl;
  logic          q_full;
  assign q_hd   = q_busy[q] ? qs[QSW-1:FW] : '0;
  assign q_fl   = q_busy[q] ? qs[FW-1:0] : '0;
  assign q_full = (q_fl >= FW'(THREADS));

  // result register is free when empty or being taken at this edge
  logic out_free, commit, res_load;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == S_COMMIT) && out_free;
  assign res_load = out_free && ((state == S_COMMIT) || (state == S_DONE) ||
                    ((state == S_SCAN) && !q_busy[q] && (32'(q) == 32'(NQ - 1))));

  logic [32:0] sum;
  logic [31:0] gain;
  assign gain = svc - prev_svc;
  assign sum  = {1'b0, run} + {1'b0, gain};

  // head wraps by width: THREADS is a power of two
  logic [TW:0] slot_w;
  assign slot_w = {1'b0, q_hd} + (TW+1)'(q_fl);
  assign ram_waddr = AW'(q) * AW'(THREADS) + AW'(slot_w[TW-1:0]);
  assign ram_wdata = 6'(tid);
  assign ram_we = commit && !q_full;
  assign ram_raddr = AW'(q) * AW'(THREADS) + AW'(q_hd);

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tvalid <= '0;
      q_busy <= '0;
      total <= '0;
    end else begin
      if (res_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            tid <= TW'(thread_id);
            cls <= QW'(thread_class);
            svc <= service_ticks;
            lvl <= t_level[TW'(thread_id)];
            run <= t_run[TW'(thread_id)];
            prev_svc <= t_last[TW'(thread_id)];
            rd_ok <= tvalid[TW'(thread_id)];
            scan_lv <= '0;
            scan_cl <= '0;
            q <= '0;
            state <= (command == mfqs_pkg::CMD_ENQ) ? S_ADD : S_SCAN;
          end
        end
        S_ADD: begin
          // never-written thread starts at level 0 with nothing run
          if (!rd_ok) begin
            lvl <= '0;
            run <= '0;
            prev_svc <= '0;
          end
          state <= S_LEVEL;
        end
        S_LEVEL: begin
          state <= S_QREAD;
          if (32'(lvl) < 32'(LEVELS - 1) &&
              (sum[32] || {1'b0, sum[31:0]} >= (33'd1 << lvl))) begin
            run <= '0;
            lvl <= lvl + LW'(1);
            q <= QW'(32'(lvl + LW'(1)) * CLASSES) + cls;
          end else begin
            run <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            q <= QW'(32'(lvl) * CLASSES) + cls;
          end
        end
        S_QREAD: begin
          qs <= q_state[q];
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (out_free) begin
            if (!q_full) begin
              status <= mfqs_pkg::ST_ENQ;
              tvalid[tid] <= 1'b1;
              t_level[tid] <= lvl;
              t_run[tid] <= run;
              t_last[tid] <= svc;
              q_state[q] <= {q_hd, q_fl + FW'(1)};
              q_busy[q] <= 1'b1;
              total <= total + 12'd1;
              waiting_count <= total + 12'd1;
            end else begin
              status <= mfqs_pkg::ST_FULL;
              waiting_count <= total;
            end
            chosen_thread <= 6'(tid);
            chosen_level <= 4'(lvl);
            slice_ticks <= mfqs_pkg::slice_of(4'(lvl));
            level_run <= run;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          qs <= q_state[q];
          if (q_busy[q]) begin
            state <= S_READ;
          end else if (32'(q) == 32'(NQ - 1)) begin
            if (out_free) begin
              status <= mfqs_pkg::ST_NONE;
              chosen_thread <= '0;
              chosen_level <= '0;
              slice_ticks <= '0;
              level_run <= '0;
              waiting_count <= total;
              state <= S_IDLE;
            end
          end else begin
            q <= q + QW'(1);
            if (32'(scan_cl) == 32'(CLASSES - 1)) begin
              scan_cl <= '0;
              scan_lv <= scan_lv + LW'(1);
            end else begin
              scan_cl <= scan_cl + QW'(1);
            end
          end
        end
        S_READ: begin
          // slot read issued this cycle; pop the FIFO
          q_state[q] <= {q_hd + TW'(1), q_fl - FW'(1)};
          q_busy[q] <= (q_fl != FW'(1));
          total <= total - 12'd1;
          state <= S_TREAD;
        end
        S_TREAD: begin
          tid <= TW'(ram_rdata);
          run <= t_run[TW'(ram_rdata)];
          rd_ok <= tvalid[TW'(ram_rdata)];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            status <= mfqs_pkg::ST_DISP;
            chosen_thread <= 6'(tid);
            chosen_level <= 4'(scan_lv);
            slice_ticks <= mfqs_pkg::slice_of(4'(scan_lv));
            level_run <= rd_ok ? run : 32'd0;
            waiting_count <= total;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a stalled result beat holds still
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(chosen_thread) && $stable(level_run) && $stable(waiting_count)))
    else $error("result changed while stalled");
  // a dispatch result never reports a level beyond the bottom
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mfqs_pkg::ST_DISP) |-> (32'(chosen_level) < LEVELS))
    else $error("bad level");
  // nothing-ready only when no entry waits
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mfqs_pkg::ST_NONE) |-> (total == 12'd0))
    else $error("none with waiting");
  // total never exceeds capacity
  assert property (@(posedge clk) disable iff (rst)
    32'(total) <= NQ * THREADS) else $error("total overflow");
endmodule

/* dv/tb_multilevel_feedback_queue_scheduler.sv */
module tb_multilevel_feedback_queue_scheduler;

  localparam int NLEV  = 10;
  localparam int NCLS  = 4;
  localparam int NTHR  = 64;
  localparam int NQ    = NLEV * NCLS;
  localparam int N_RANDOM = 780;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [5:0]  thread_id;
  logic [1:0]  thread_class;
  logic [31:0] service_ticks;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [5:0]  chosen_thread;
  logic [3:0]  chosen_level;
  logic [9:0]  slice_ticks;
  logic [31:0] level_run;
  logic [11:0] waiting_count;

  multilevel_feedback_queue_scheduler i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .thread_id(thread_id),
    .thread_class(thread_class), .service_ticks(service_ticks),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .chosen_thread(chosen_thread),
    .chosen_level(chosen_level), .slice_ticks(slice_ticks),
    .level_run(level_run), .waiting_count(waiting_count)
  );

  // One result beat.
  typedef struct packed {
    logic [1:0]  st;
    logic [5:0]  thr;
    logic [3:0]  lvl;
    logic [9:0]  slc;
    logic [31:0] run;
    logic [11:0] wait_n;
  } sched_result_t;

  // One command beat plus an optional hand-typed expectation.
  typedef struct {
    logic        cmd;
    logic [5:0]  tid;
    logic [1:0]  cls;
    logic [31:0] svc;
    bit          typed;
    sched_result_t res;
  } cmd_row_t;

  // Scheduler shadow state.
  logic [5:0]  q_slots [NQ][NTHR];
  int unsigned q_head  [NQ];
  int unsigned q_fill  [NQ];
  logic [3:0]  thr_lvl [NTHR];
  logic [31:0] thr_run [NTHR];
  logic [31:0] thr_svc [NTHR];
  int unsigned n_waiting;

  sched_result_t pending_results[$];
  sched_result_t typed_results[$];
  bit            typed_flags[$];
  int            n_errors = 0;
  longint        cycle_cnt = 0;
  bit            hold_req = 1'b0;

  function automatic logic [9:0] slice_for(int unsigned lv);
    return (lv < 10) ? 10'(1 << lv) : 10'd0;
  endfunction

  // Advance the shadow scheduler by one command; return what the block must say.
  function automatic sched_result_t schedule_step(logic cmd, logic [5:0] tid_in,
                                                  logic [1:0] cls_in, logic [31:0] svc);
    sched_result_t r;
    int unsigned lv, cls, q, tid;
    logic [31:0] gain, run;
    r = '0;
    if (cmd == mfqs_pkg::CMD_ENQ) begin
      tid  = tid_in % NTHR;
      cls  = cls_in % NCLS;
      lv   = int'(thr_lvl[tid]);
      gain = svc - thr_svc[tid];
      run  = (thr_run[tid] > 32'hFFFF_FFFF - gain) ? 32'hFFFF_FFFF : thr_run[tid] + gain;
      if (lv >= NLEV) lv = NLEV - 1;
      // drop one level once the level's quota is used up; bottom level keeps its count
      if (lv < NLEV - 1 && 64'(run) >= (64'd1 << lv)) begin
        run = '0;
        lv++;
      end
      q = lv * NCLS + cls;
      r.thr = 6'(tid);
      r.lvl = 4'(lv);
      r.slc = slice_for(lv);
      r.run = run;
      if (q_fill[q] >= NTHR) begin
        r.st = mfqs_pkg::ST_FULL;
      end else begin
        thr_lvl[tid] = 4'(lv);
        thr_run[tid] = run;
        thr_svc[tid] = svc;
        q_slots[q][(q_head[q] + q_fill[q]) % NTHR] = 6'(tid);
        q_fill[q]++;
        n_waiting++;
        r.st = mfqs_pkg::ST_ENQ;
      end
      r.wait_n = 12'(n_waiting);
      return r;
    end
    for (int l = 0; l < NLEV; l++) begin
      for (int c = 0; c < NCLS; c++) begin
        q = l * NCLS + c;
        if (q_fill[q] != 0) begin
          tid = int'(q_slots[q][q_head[q]]);
          q_head[q] = (q_head[q] + 1) % NTHR;
          q_fill[q]--;
          n_waiting--;
          r.st = mfqs_pkg::ST_DISP;
          r.thr = 6'(tid);
          r.lvl = 4'(l);
          r.slc = slice_for(l);
          r.run = thr_run[tid];
          r.wait_n = 12'(n_waiting);
          return r;
        end
      end
    end
    r.st = mfqs_pkg::ST_NONE;
    r.wait_n = 12'(n_waiting);
    return r;
  endfunction

  // Clock and cycle watchdog.
  initial begin
    clk = 1'b0;
    forever begin
      #4 clk = ~clk;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: compare every accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    sched_result_t exp_r, typed_r;
    bit            has_typed;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        exp_r     = pending_results.pop_front();
        typed_r   = typed_results.pop_front();
        has_typed = typed_flags.pop_front();
        // hand-typed rows must agree with the predictor too
        if (has_typed && typed_r != exp_r) begin
          $error("typed row disagrees with prediction: typed %h predicted %h",
                 typed_r, exp_r);
          n_errors++;
        end
        if (status !== exp_r.st) begin
          $error("status: expected %0d actual %0d", exp_r.st, status);
          n_errors++;
        end
        if (chosen_thread !== exp_r.thr) begin
          $error("chosen_thread: expected %0d actual %0d", exp_r.thr, chosen_thread);
          n_errors++;
        end
        if (chosen_level !== exp_r.lvl) begin
          $error("chosen_level: expected %0d actual %0d", exp_r.lvl, chosen_level);
          n_errors++;
        end
        if (slice_ticks !== exp_r.slc) begin
          $error("slice_ticks: expected %0d actual %0d", exp_r.slc, slice_ticks);
          n_errors++;
        end
        if (level_run !== exp_r.run) begin
          $error("level_run: expected %0d actual %0d", exp_r.run, level_run);
          n_errors++;
        end
        if (waiting_count !== exp_r.wait_n) begin
          $error("waiting_count: expected %0d actual %0d", exp_r.wait_n, waiting_count);
          n_errors++;
        end
      end
    end
  end

  // Receiver stall pattern: mostly short random stalls, quiet stretches, and one
  // long hold-off requested by the stimulus so the block backs up.
  initial begin
    int mode;
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b1;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        @(posedge clk);
      end
    end
  end

  // Push one command beat; valid stays up across back-to-back beats.
  task automatic send_cmd(logic cmd, logic [5:0] tid, logic [1:0] cls,
                          logic [31:0] svc, bit typed, sched_result_t tr);
    in_valid      <= 1'b1;
    command       <= cmd;
    thread_id     <= tid;
    thread_class  <= cls;
    service_ticks <= svc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    pending_results.push_back(schedule_step(cmd, tid, cls, svc));
    typed_results.push_back(tr);
    typed_flags.push_back(typed);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  cmd_row_t    dir_rows[$];
  int          burst;
  logic [31:0] last_svc [NTHR];

  function automatic sched_result_t mk(logic [1:0] st, logic [5:0] thr, logic [3:0] lvl,
                                       logic [9:0] slc, logic [31:0] run,
                                       logic [11:0] w);
    sched_result_t r;
    r.st = st; r.thr = thr; r.lvl = lvl; r.slc = slc; r.run = run; r.wait_n = w;
    return r;
  endfunction

  function automatic cmd_row_t row(logic cmd, logic [5:0] tid, logic [1:0] cls,
                                   logic [31:0] svc, bit typed, sched_result_t r);
    cmd_row_t x;
    x.cmd = cmd; x.tid = tid; x.cls = cls; x.svc = svc; x.typed = typed; x.res = r;
    return x;
  endfunction

  initial begin
    sched_result_t nil;
    logic [5:0]  tid;
    logic [31:0] svc;
    int          pick;
    nil = '0;
    n_waiting = 0;
    for (int q = 0; q < NQ; q++) begin
      q_head[q] = 0;
      q_fill[q] = 0;
    end
    for (int t = 0; t < NTHR; t++) begin
      thr_lvl[t] = '0; thr_run[t] = '0; thr_svc[t] = '0; last_svc[t] = '0;
    end
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    command       <= mfqs_pkg::CMD_ENQ;
    thread_id     <= '0;
    thread_class  <= '0;
    service_ticks <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Typed rows: empty dispatch, first enqueues, extremes.
    dir_rows.push_back(row(mfqs_pkg::CMD_DISP, 6'd0, 2'd0, 32'd0, 1'b1,
                           mk(mfqs_pkg::ST_NONE, 6'd0, 4'd0, 10'd0, 32'd0, 12'd0)));
    // zero service at level 0: run 0 < 1, stays
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd0, 2'd0, 32'd0, 1'b1,
                           mk(mfqs_pkg::ST_ENQ, 6'd0, 4'd0, 10'd1, 32'd0, 12'd1)));
    // one tick at level 0 drops to level 1, count cleared
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd63, 2'd3, 32'd1, 1'b1,
                           mk(mfqs_pkg::ST_ENQ, 6'd63, 4'd1, 10'd2, 32'd0, 12'd2)));
    // all-ones service: big gain, drops a level
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd42, 2'd2, 32'hFFFF_FFFF, 1'b1,
                           mk(mfqs_pkg::ST_ENQ, 6'd42, 4'd1, 10'd2, 32'd0, 12'd3)));
    // service wrapping past all-ones gives a small gain; going backwards wraps to a huge gain
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd42, 2'd1, 32'd5, 1'b0, nil));
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd42, 2'd1, 32'd0, 1'b0, nil));
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd21, 2'd1, 32'h5555_5555, 1'b0, nil));
    dir_rows.push_back(row(mfqs_pkg::CMD_ENQ, 6'd0,  2'd0, 32'hAAAA_AAAA, 1'b0, nil));
    // class ordering and FIFO order through dispatch
    for (int i = 0; i < 7; i++) begin
      dir_rows.push_back(row(mfqs_pkg::CMD_DISP, 6'd63, 2'd3, 32'd0, 1'b0, nil));
    end
    dir_rows.push_back(row(mfqs_pkg::CMD_DISP, 6'd0, 2'd0, 32'd0, 1'b1,
                           mk(mfqs_pkg::ST_NONE, 6'd0, 4'd0, 10'd0, 32'd0, 12'd0)));
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].tid, dir_rows[i].cls, dir_rows[i].svc,
               dir_rows[i].typed, dir_rows[i].res);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
    end
    for (int t = 0; t < NTHR; t++) last_svc[t] = thr_svc[t];

    // Walk one thread down to the bottom level with doubling service steps.
    svc = thr_svc[7];
    for (int l = 0; l < 11; l++) begin
      svc = svc + (32'd1 << l);
      send_cmd(mfqs_pkg::CMD_ENQ, 6'd7, 2'd2, svc, 1'b0, nil);
    end
    last_svc[7] = thr_svc[7];

    // Fill one FIFO to overflow: thread 3 at level 0 class 0, zero gain.
    hold_req = 1'b1;
    for (int i = 0; i < NTHR + 3; i++) begin
      send_cmd(mfqs_pkg::CMD_ENQ, 6'd3, 2'd0, thr_svc[3], 1'b0, nil);
    end
    while (n_waiting > 0) begin
      send_cmd(mfqs_pkg::CMD_DISP, 6'($urandom), 2'($urandom), $urandom, 1'b0, nil);
    end

    // Random part: service mostly grows by small amounts so threads move through
    // the levels; some wild values and backwards jumps.
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        tid  = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          svc = thr_svc[tid] + $urandom_range(0, 1 << $urandom_range(0, 10));
          send_cmd(mfqs_pkg::CMD_ENQ, tid, 2'($urandom), svc, 1'b0, nil);
        end else if (pick < 52) begin
          send_cmd(mfqs_pkg::CMD_ENQ, tid, 2'($urandom), $urandom, 1'b0, nil);
        end else begin
          send_cmd(mfqs_pkg::CMD_DISP, 6'($urandom), 2'($urandom), $urandom, 1'b0, nil);
        end
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
